>>> rtl/core/binary_avg_pool_2x2_macros.svh
// Assertion macros for the binary 2x2 pooling block.
// Used by the port-level checker; no other dependencies.
`ifndef BINARY_AVG_POOL_2X2_MACROS_SVH
`define BINARY_AVG_POOL_2X2_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bap check failed");

// next-cycle implication, disabled while reset is low
`define BAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bap check failed");

`endif

>>> rtl/core/bap_pkg.sv
// Shared types, constants and the window pooling function.
// No dependencies.
`timescale 1ns / 1ps

package bap_pkg;

    localparam int PIX_W      = 8;
    localparam int POOL_W     = 4;
    localparam int ROW_LEN_W  = 7;
    localparam int WIN_THRESH = 2;

    typedef struct packed {
        logic odd;
        logic last;
    } t_item_ctl;

    // bit k of the result is window k: pixels 2k and 2k+1 of both rows
    function automatic logic [POOL_W-1:0] pool_byte(
        input logic [PIX_W-1:0] top,
        input logic [PIX_W-1:0] bottom
    );
        logic [POOL_W-1:0] res;
        logic [2:0]        cnt;
        res = '0;
        for (int k = 0; k < POOL_W; k++) begin
            cnt = 3'(top[2*k]) + 3'(top[2*k+1]) + 3'(bottom[2*k]) + 3'(bottom[2*k+1]);
            res[k] = (cnt >= 3'(WIN_THRESH));
        end
        return res;
    endfunction

endpackage

>>> rtl/core/binary_avg_pool_2x2.sv
// An accepted odd-row byte passes stage 1, then the output register; even rows give none.
// Throughput: one byte per cycle unless stalled; even rows write the store, odd read it.
// Reset (i_rst_n low, synchronous): clears counters, row length to 1, valid flags.
// Line store content is not cleared; even rows fill it before it is read.
// Top level: binary 2x2 pooling over packed bit rows. Depends on bap_pkg,
// bap_ctrl, bap_line_buf and bap_pool_out.
`timescale 1ns / 1ps

module binary_avg_pool_2x2 #(
    parameter int MAX_ROW_BYTES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] pixel_byte
    input  logic                               i_s_tuser,   // [0] frame_start
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [7:0]                         o_m_tdata,   // [3:0] pooled_bits, [7:4] zero
    output logic                               o_m_tlast,   // row_last
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bap_pkg::ROW_LEN_W-1:0]      i_cfg_data   // row_bytes
);

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic                          accept;
    logic [COL_W-1:0]              col;
    bap_pkg::t_item_ctl            ctl;
    logic                          out_free;
    logic [bap_pkg::PIX_W-1:0]     top;
    logic [bap_pkg::POOL_W-1:0]    pool_bits;
    logic                          s1_load;

    logic                          r_s1_valid;
    logic [bap_pkg::PIX_W-1:0]     r_s1_pixel;
    logic                          r_s1_last;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_s1_valid || out_free;
    assign accept      = i_s_tvalid && o_s_tready;
    assign s1_load     = accept && ctl.odd;

    bap_ctrl #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .COL_W         (COL_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_frame_start (i_s_tuser),
        .o_col         (col),
        .o_ctl         (ctl)
    );

    bap_line_buf #(
        .DEPTH   (MAX_ROW_BYTES),
        .ADDR_W  (COL_W)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (accept && !ctl.odd),
        .i_re    (s1_load),
        .i_addr  (col),
        .i_wdata (i_s_tdata),
        .o_rdata (top)
    );

    // stage 1 lines up the odd-row byte with the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_pixel <= i_s_tdata;
            r_s1_last  <= ctl.last;
        end
    end

    bap_pool_out u_pool_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_top      (top),
        .i_bottom   (r_s1_pixel),
        .i_last     (r_s1_last),
        .o_free     (out_free),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_bits     (pool_bits),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {(8 - bap_pkg::POOL_W)'(0), pool_bits};

endmodule

>>> rtl/core/bap_ctrl.sv
// Row length register, column and row-parity counters.
// Depends on bap_pkg.
`timescale 1ns / 1ps

module bap_ctrl #(
    parameter int MAX_ROW_BYTES = 64,
    parameter int COL_W         = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bap_pkg::ROW_LEN_W-1:0]     i_cfg_data,
    input  logic                              i_accept,
    input  logic                              i_frame_start,
    output logic [COL_W-1:0]                  o_col,
    output bap_pkg::t_item_ctl                o_ctl
);

    localparam int CMP_W = (COL_W + 1 > bap_pkg::ROW_LEN_W) ? COL_W + 1 : bap_pkg::ROW_LEN_W;

    logic [bap_pkg::ROW_LEN_W-1:0] r_row_bytes;
    logic [COL_W-1:0]              r_col, n_col;
    logic                          r_odd, n_odd;
    logic [CMP_W-1:0]              rb_ext, limit, col_inc;
    logic                          last;

    always_comb begin
        o_col   = i_frame_start ? '0 : r_col;
        rb_ext  = CMP_W'(r_row_bytes);
        if (rb_ext == '0) begin
            limit = CMP_W'(1);
        end else if (rb_ext > CMP_W'(MAX_ROW_BYTES)) begin
            limit = CMP_W'(MAX_ROW_BYTES);
        end else begin
            limit = rb_ext;
        end
        col_inc = CMP_W'(o_col) + CMP_W'(1);
        last    = (col_inc >= limit);
        o_ctl.odd  = i_frame_start ? 1'b0 : r_odd;
        o_ctl.last = last;
        n_col = last ? '0 : col_inc[COL_W-1:0];
        n_odd = last ? ~o_ctl.odd : o_ctl.odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= bap_pkg::ROW_LEN_W'(1);
            r_col       <= '0;
            r_odd       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_bytes <= i_cfg_data;
            end
            if (i_accept) begin
                r_col <= n_col;
                r_odd <= n_odd;
            end
        end
    end

endmodule

>>> rtl/core/bap_line_buf.sv
// Line store for even-row bytes with a registered read port.
// Depends on bap_pkg.
`timescale 1ns / 1ps

module bap_line_buf #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic [bap_pkg::PIX_W-1:0]     i_wdata,
    output logic [bap_pkg::PIX_W-1:0]     o_rdata
);

    logic [bap_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [bap_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bap_pool_out.sv
// Window pooling and the output register with its handshake.
// Depends on bap_pkg.
`timescale 1ns / 1ps

module bap_pool_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s1_valid,
    input  logic [bap_pkg::PIX_W-1:0]      i_top,
    input  logic [bap_pkg::PIX_W-1:0]      i_bottom,
    input  logic                           i_last,
    output logic                           o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bap_pkg::POOL_W-1:0]     o_bits,
    output logic                           o_last
);

    logic                        r_valid;
    logic [bap_pkg::POOL_W-1:0]  r_bits;
    logic                        r_last;
    logic                        load;

    assign o_free = !r_valid || i_ready;
    assign load   = i_s1_valid && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits <= bap_pkg::pool_byte(i_top, i_bottom);
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;
    assign o_last  = r_last;

endmodule

>>> rtl/core/bap_checker.sv
// Port-level checks for binary_avg_pool_2x2, attached by bind.
// Depends on binary_avg_pool_2x2_macros.svh.
`timescale 1ns / 1ps
`include "binary_avg_pool_2x2_macros.svh"

module bap_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [7:0]                         o_m_tdata,
    input  logic                               o_m_tlast
);

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // nothing comes out right after reset
    `BAP_ASSERT_NXT(a_rst_clears, i_clk, 1'b1, !i_rst_n, !o_m_tvalid)
    // a stalled result holds
    `BAP_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    // padding bits of the result word stay zero
    `BAP_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[7:4] == 4'd0)
    // a result appearing on an empty output follows an input accepted through stage 1 and the output register
    `BAP_ASSERT_IMP(a_cause, i_clk, i_rst_n, $rose(o_m_tvalid), $past(s_acc, 2))
    // an empty output with no pending data always takes input
    `BAP_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

endmodule

bind binary_avg_pool_2x2 bap_checker u_bap_checker (.*);
